### rtl/rieu_pkg.sv
// Package: operation codes, queue entry types and constants of the execute unit.
`timescale 1ns / 1ps
package rieu_pkg;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [5:0] {
    OP_ADD = 6'd0, OP_ADDC = 6'd1, OP_SUB = 6'd2, OP_MUL = 6'd3, OP_MULU = 6'd4,
    OP_DIV = 6'd5, OP_DIVU = 6'd6, OP_AND = 6'd7, OP_OR = 6'd8, OP_XOR = 6'd9,
    OP_MOVHI = 6'd10, OP_SLL = 6'd11, OP_SRL = 6'd12, OP_SRA = 6'd13, OP_ROR = 6'd14,
    OP_EQ = 6'd15, OP_NE = 6'd16, OP_GTS = 6'd17, OP_GES = 6'd18, OP_LTS = 6'd19,
    OP_LES = 6'd20, OP_GTU = 6'd21, OP_GEU = 6'd22, OP_LTU = 6'd23, OP_LEU = 6'd24,
    OP_EXTBS = 6'd25, OP_EXTBZ = 6'd26, OP_EXTHS = 6'd27, OP_EXTHZ = 6'd28,
    OP_CMOV = 6'd29, OP_FF1 = 6'd30, OP_FL1 = 6'd31, OP_MAC = 6'd32, OP_MSB = 6'd33,
    OP_MACRC = 6'd34
  } op_e;

  // Operation class chosen by the front end.
  typedef enum logic [2:0] {
    CL_SIMPLE, CL_MUL, CL_DIV, CL_MAC, CL_NOP
  } class_e;

  typedef enum logic [1:0] {
    ST_IDLE, ST_MUL, ST_DIV, ST_DONE
  } state_e;

  typedef struct packed {
    logic [5:0]  cmd;
    class_e      cls;
    logic [31:0] a;
    logic [31:0] b;
  } entry_t;

  typedef struct packed {
    logic [31:0] result;
    logic        writes_result;
    logic        flag_out;
    logic        carry_out;
    logic        overflow_out;
    logic        range_exception;
  } res_t;

  localparam logic [31:0] Sign32 = 32'h8000_0000;

endpackage

### rtl/rieu_if.sv
// Interfaces: valid/ready channels for operations and results.
`timescale 1ns / 1ps
interface rieu_in_if;
  logic        valid;
  logic        ready;
  logic [5:0]  cmd;
  logic [31:0] operand_a;
  logic [31:0] operand_b;
  modport source (output valid, cmd, operand_a, operand_b, input ready);
  modport sink (input valid, cmd, operand_a, operand_b, output ready);
endinterface

interface rieu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result;
  logic        writes_result;
  logic        flag_out;
  logic        carry_out;
  logic        overflow_out;
  logic        range_exception;
  modport source (output valid, result, writes_result, flag_out, carry_out,
                  overflow_out, range_exception, input ready);
  modport sink (input valid, result, writes_result, flag_out, carry_out,
                overflow_out, range_exception, output ready);
endinterface

### rtl/rieu_front.sv
// Front end: accept operations, classify them and queue them for the back end.
`timescale 1ns / 1ps
module rieu_front
  import rieu_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  logic [5:0]  cmd_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic   q_valid_o,
  input  logic   q_ready_i,
  output entry_t q_entry_o
);
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  entry_t        mem_q [Depth];
  logic [Aw-1:0] wp_q, rp_q;
  logic [Aw:0]   cnt_q;
  class_e        cls;
  logic          push, pop;

  // Classify the operation code.
  always_comb begin
    case (cmd_i)
      OP_MUL, OP_MULU:         cls = CL_MUL;
      OP_DIV, OP_DIVU:         cls = CL_DIV;
      OP_MAC, OP_MSB:          cls = CL_MAC;
      default: begin
        if (cmd_i <= OP_MACRC) cls = CL_SIMPLE;
        else                   cls = CL_NOP;
      end
    endcase
  end

  assign in_ready_o = (cnt_q != Depth[Aw:0]);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_entry_o  = mem_q[rp_q];

  // Write the queue on a transfer.
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= '{cmd: cmd_i, cls: cls, a: a_i, b: b_i};
  end

  // Advance pointers and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == Aw'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (pop)  rp_q <= (rp_q == Aw'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(push) - (Aw+1)'(pop);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= Depth[Aw:0])
    else $error("queue count above depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> !pop) else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count lost a push");
endmodule

### rtl/rieu_back.sv
// Back end: execute queued operations, keep flags and accumulator, hold result.
`timescale 1ns / 1ps
module rieu_back
  import rieu_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   trap_en_i,
  input  logic   q_valid_i,
  output logic   q_ready_o,
  input  entry_t q_entry_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output res_t   out_res_o
);
  state_e      st_q, st_d;
  logic        flag_q, carry_q, ovf_q;
  logic [63:0] acc_q;
  entry_t      e_q;
  res_t        res_q;
  logic        rvalid_q;
  // multiply stage: unsigned product, signed top bits derived from it
  logic [63:0] pu_q;
  logic [32:0] ps_top;
  logic        mul_ovf;
  // divider
  logic [31:0] dq_q, drem_q, dd_q;
  logic [5:0]  dcnt_q;
  logic        dneg_q;

  logic        take, fin_simple, fin_mul, fin_div;
  res_t        sres;
  logic        nflag;
  logic [63:0] nacc;
  logic [32:0] sum, diff;
  logic [31:0] ma, mb, sh_a;
  logic [4:0]  sh;
  logic [32:0] rtry;
  logic [5:0]  lo1, hi1;

  assign q_ready_o   = (st_q == ST_IDLE) && !rvalid_q;
  assign take        = q_valid_i && q_ready_o;
  assign out_valid_o = rvalid_q;
  assign out_res_o   = res_q;

  // Simple operations evaluated straight from the queue head.
  always_comb begin
    logic [31:0] a, b;
    a = q_entry_i.a;
    b = q_entry_i.b;
    sh = b[4:0];
    sum  = {1'b0, a} + {1'b0, b} +
           33'((q_entry_i.cmd == OP_ADDC) ? carry_q : 1'b0);
    diff = {1'b0, a} - {1'b0, b};
    sh_a = 32'($signed(a) >>> sh);
    lo1 = '0;
    for (int i = 31; i >= 0; i--) if (a[i]) lo1 = 6'(i + 1);
    hi1 = '0;
    for (int i = 0; i < 32; i++) if (a[i]) hi1 = 6'(i + 1);
    sres   = '{result: '0, writes_result: 1'b1, flag_out: flag_q, carry_out: carry_q,
               overflow_out: ovf_q, range_exception: 1'b0};
    nflag  = flag_q;
    nacc   = acc_q;
    case (q_entry_i.cmd)
      OP_ADD, OP_ADDC: begin
        sres.result = sum[31:0];
        sres.carry_out = sum[32];
        sres.overflow_out = ~(a[31] ^ b[31]) & (a[31] ^ sum[31]);
        sres.range_exception = trap_en_i & sres.overflow_out;
      end
      OP_SUB: begin
        sres.result = diff[31:0];
        sres.carry_out = diff[32];
        sres.overflow_out = (a[31] ^ b[31]) & (a[31] ^ diff[31]);
        sres.range_exception = trap_en_i & sres.overflow_out;
      end
      OP_AND:   sres.result = a & b;
      OP_OR:    sres.result = a | b;
      OP_XOR:   sres.result = a ^ b;
      OP_MOVHI: sres.result = {a[15:0], 16'h0};
      OP_SLL:   sres.result = a << sh;
      OP_SRL:   sres.result = a >> sh;
      OP_SRA:   sres.result = sh_a;
      OP_ROR:   sres.result = (a >> sh) | (a << (6'd32 - {1'b0, sh}));
      OP_EQ:    nflag = (a == b);
      OP_NE:    nflag = (a != b);
      OP_GTS:   nflag = $signed(a) >  $signed(b);
      OP_GES:   nflag = $signed(a) >= $signed(b);
      OP_LTS:   nflag = $signed(a) <  $signed(b);
      OP_LES:   nflag = $signed(a) <= $signed(b);
      OP_GTU:   nflag = a >  b;
      OP_GEU:   nflag = a >= b;
      OP_LTU:   nflag = a <  b;
      OP_LEU:   nflag = a <= b;
      OP_EXTBS: sres.result = {{24{a[7]}}, a[7:0]};
      OP_EXTBZ: sres.result = {24'h0, a[7:0]};
      OP_EXTHS: sres.result = {{16{a[15]}}, a[15:0]};
      OP_EXTHZ: sres.result = {16'h0, a[15:0]};
      OP_CMOV:  sres.result = flag_q ? a : b;
      OP_FF1:   sres.result = {26'h0, lo1};
      OP_FL1:   sres.result = {26'h0, hi1};
      OP_MACRC: begin
        sres.result = acc_q[31:0];
        nacc = '0;
      end
      default:  sres.writes_result = 1'b0;
    endcase
    if (q_entry_i.cmd >= OP_EQ && q_entry_i.cmd <= OP_LEU) sres.writes_result = 1'b0;
    sres.flag_out = nflag;
    ma = a[31] ? 32'(-a) : a;
    mb = b[31] ? 32'(-b) : b;
  end

  assign rtry = {drem_q, dq_q[31]} - {1'b0, dd_q};

  // Correct the unsigned product's high word for negative operands.
  assign ps_top  = {pu_q[63:32] - (e_q.a[31] ? e_q.b : 32'h0) -
                    (e_q.b[31] ? e_q.a : 32'h0), pu_q[31]};
  assign mul_ovf = (e_q.cmd == OP_MUL) && (ps_top != '0) && (ps_top != '1);

  // Next state of the sequencer.
  always_comb begin
    st_d = st_q;
    fin_simple = 1'b0;
    fin_mul = 1'b0;
    fin_div = 1'b0;
    case (st_q)
      ST_IDLE: if (take) begin
        case (q_entry_i.cls)
          CL_MUL, CL_MAC: st_d = ST_MUL;
          CL_DIV: st_d = (q_entry_i.b == '0) ? ST_IDLE : ST_DIV;
          default: st_d = ST_IDLE;
        endcase
        fin_simple = (q_entry_i.cls == CL_SIMPLE) || (q_entry_i.cls == CL_NOP) ||
                     ((q_entry_i.cls == CL_DIV) && (q_entry_i.b == '0));
      end
      ST_MUL: begin
        st_d = ST_IDLE;
        fin_mul = 1'b1;
      end
      ST_DIV: if (dcnt_q == 6'd31) begin
        st_d = ST_DONE;
      end
      ST_DONE: begin
        st_d = ST_IDLE;
        fin_div = 1'b1;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= ST_IDLE;
    else         st_q <= st_d;
  end

  // Datapath registers: operands, product, divider.
  always_ff @(posedge clk_i) begin
    if (take) begin
      e_q  <= q_entry_i;
      pu_q <= {32'h0, q_entry_i.a} * {32'h0, q_entry_i.b};
      dneg_q <= (q_entry_i.cmd == OP_DIV) && (q_entry_i.a[31] ^ q_entry_i.b[31]);
      dq_q   <= (q_entry_i.cmd == OP_DIV) ? ma : q_entry_i.a;
      dd_q   <= (q_entry_i.cmd == OP_DIV) ? mb : q_entry_i.b;
      drem_q <= '0;
      dcnt_q <= '0;
    end else if (st_q == ST_DIV) begin
      // One restoring step per cycle.
      if (!rtry[32]) begin
        drem_q <= rtry[31:0];
        dq_q   <= {dq_q[30:0], 1'b1};
      end else begin
        drem_q <= {drem_q[30:0], dq_q[31]};
        dq_q   <= {dq_q[30:0], 1'b0};
      end
      dcnt_q <= dcnt_q + 1'b1;
    end
  end

  // Flags, accumulator and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0; carry_q <= 1'b0; ovf_q <= 1'b0;
      acc_q <= '0; rvalid_q <= 1'b0; res_q <= '0;
    end else begin
      if (rvalid_q && out_ready_i) rvalid_q <= 1'b0;
      if (fin_simple) begin
        rvalid_q <= 1'b1;
        flag_q   <= nflag;
        acc_q    <= nacc;
        if (q_entry_i.cls == CL_DIV) begin
          res_q <= '{result: '0, writes_result: 1'b0, flag_out: flag_q,
                     carry_out: 1'b1, overflow_out: 1'b0, range_exception: trap_en_i};
          carry_q <= 1'b1;
          ovf_q   <= 1'b0;
        end else begin
          res_q   <= sres;
          carry_q <= sres.carry_out;
          ovf_q   <= sres.overflow_out;
        end
      end
      if (fin_mul) begin
        if (e_q.cls == CL_MAC) begin
          acc_q <= (e_q.cmd == OP_MAC) ? acc_q + {{32{pu_q[31]}}, pu_q[31:0]}
                                      : acc_q - {{32{pu_q[31]}}, pu_q[31:0]};
          res_q <= '{result: '0, writes_result: 1'b0, flag_out: flag_q,
                     carry_out: carry_q, overflow_out: ovf_q, range_exception: 1'b0};
        end else begin
          carry_q <= (pu_q[63:32] != '0);
          ovf_q   <= mul_ovf;
          res_q <= '{result: pu_q[31:0], writes_result: 1'b1, flag_out: flag_q,
                     carry_out: (pu_q[63:32] != '0), overflow_out: mul_ovf,
                     range_exception: trap_en_i && mul_ovf};
        end
        rvalid_q <= 1'b1;
      end
      if (fin_div) begin
        carry_q <= 1'b0;
        ovf_q   <= 1'b0;
        res_q <= '{result: dneg_q ? 32'(-dq_q) : dq_q, writes_result: 1'b1,
                   flag_out: flag_q, carry_out: 1'b0, overflow_out: 1'b0,
                   range_exception: 1'b0};
        rvalid_q <= 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> !rvalid_q && (st_q == ST_IDLE)) else $error("take while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DIV) |-> !rvalid_q) else $error("result pending during divide");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvalid_q && !out_ready_i |=> rvalid_q) else $error("result dropped");
endmodule

### rtl/risc_integer_execute_unit.sv
// Top level of the integer execute unit: front queue and back end.
//   channel | dir | handshake   | payload
//   in_ch   | in  | valid/ready | cmd, operand_a, operand_b
//   out_ch  | out | valid/ready | result, flags, range_exception
//   cfg     | in  | we only     | overflow_trap_enable
// From input transfer to result: the front queue, then simple operations and divide by
// zero finish when the back end takes them, multiply and mac pass the product register,
// and divide runs 32 restoring steps in the divider. One operation at a time runs in the
// back end and the next one starts the cycle after its result transfers; the front queue
// of QueueDepth entries keeps accepting while not full. Reset clears flags, accumulator,
// queue and trap enable. A stalled result holds the back end until it is taken.
`timescale 1ns / 1ps
module risc_integer_execute_unit
  import rieu_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  rieu_in_if.sink    in_ch,
  rieu_out_if.source out_ch
);
  logic   trap_en_q;
  logic   qv, qr;
  entry_t qe;
  res_t   r;

  // Hold the trap enable register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       trap_en_q <= 1'b0;
    else if (cfg_we_i) trap_en_q <= cfg_wdata_i;
  end

  rieu_front #(.Depth(Depth)) u_front (
    .clk_i, .rst_ni, .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready),
    .cmd_i(in_ch.cmd), .a_i(in_ch.operand_a), .b_i(in_ch.operand_b),
    .q_valid_o(qv), .q_ready_i(qr), .q_entry_o(qe));

  rieu_back u_back (
    .clk_i, .rst_ni, .trap_en_i(trap_en_q), .q_valid_i(qv), .q_ready_o(qr),
    .q_entry_i(qe), .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready),
    .out_res_o(r));

  assign out_ch.result          = r.result;
  assign out_ch.writes_result   = r.writes_result;
  assign out_ch.flag_out        = r.flag_out;
  assign out_ch.carry_out       = r.carry_out;
  assign out_ch.overflow_out    = r.overflow_out;
  assign out_ch.range_exception = r.range_exception;
endmodule

### sim/risc_integer_execute_unit_tb.sv
// Testbench for the integer execute unit: random and directed operations checked by a predictor.
`timescale 1ns / 1ps
module risc_integer_execute_unit_tb;
  import rieu_pkg::*;

  typedef struct {
    logic [5:0]  cmd;
    logic [31:0] a;
    logic [31:0] b;
  } op_item_t;

  typedef struct {
    logic [31:0] result;
    logic        wr;
    logic        flag;
    logic        carry;
    logic        ovf;
    logic        exc;
  } alu_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;

  rieu_in_if  in_ch ();
  rieu_out_if out_ch ();

  risc_integer_execute_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch.sink),
    .out_ch      (out_ch.source)
  );

  always #1 clk_i = ~clk_i;

  // Predictor state
  logic        trap_en;
  logic        cmp_flag, carry_flag, ovf_flag;
  logic [63:0] mac_acc;

  op_item_t pending_ops[$];
  alu_res_t expected_res[$];
  int       mismatches = 0;
  int       results_seen = 0;
  bit       idle_enable = 1'b1;
  bit       sender_hold = 1'b0;
  bit       long_stall = 1'b0;
  int       send_gap = 0;
  int       recv_gap = 0;

  function automatic logic [31:0] find_low_one(logic [31:0] v);
    for (int i = 0; i < 32; i++) begin
      if (v[i]) return i + 1;
    end
    return 0;
  endfunction

  function automatic logic [31:0] find_high_one(logic [31:0] v);
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) return i + 1;
    end
    return 0;
  endfunction

  // Compute the expected result of one operation and advance flag state.
  function automatic alu_res_t alu_predict(op_item_t op);
    alu_res_t    r;
    logic [32:0] s;
    logic [63:0] p, pu, t;
    logic [31:0] a, b, ma, mb, q;
    logic [4:0]  sh;
    logic        cmpf, is_cmp;
    a = op.a;
    b = op.b;
    sh = b[4:0];
    r.result = '0;
    r.wr = 1'b1;
    r.exc = 1'b0;
    is_cmp = 1'b0;
    cmpf = 1'b0;
    case (op.cmd)
      OP_ADD, OP_ADDC: begin
        s = {1'b0, a} + {1'b0, b} + ((op.cmd == OP_ADDC) ? carry_flag : 1'b0);
        r.result = s[31:0];
        carry_flag = s[32];
        ovf_flag = ~(a[31] ^ b[31]) & (a[31] ^ s[31]);
        r.exc = trap_en & ovf_flag;
      end
      OP_SUB: begin
        r.result = a - b;
        carry_flag = b > a;
        ovf_flag = (a[31] ^ b[31]) & (a[31] ^ r.result[31]);
        r.exc = trap_en & ovf_flag;
      end
      OP_MUL: begin
        p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
        pu = {32'd0, a} * {32'd0, b};
        r.result = p[31:0];
        ovf_flag = p[63:31] != {33{1'b0}} && p[63:31] != {33{1'b1}};
        carry_flag = pu[63:32] != 0;
        r.exc = trap_en & ovf_flag;
      end
      OP_MULU: begin
        pu = {32'd0, a} * {32'd0, b};
        r.result = pu[31:0];
        ovf_flag = 1'b0;
        carry_flag = pu[63:32] != 0;
      end
      OP_DIV, OP_DIVU: begin
        ovf_flag = 1'b0;
        if (b == 0) begin
          carry_flag = 1'b1;
          r.wr = 1'b0;
        end else begin
          carry_flag = 1'b0;
          if (op.cmd == OP_DIVU) begin
            r.result = a / b;
          end else begin
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            q = ma / mb;
            r.result = (a[31] != b[31]) ? -q : q;
          end
        end
        r.exc = trap_en & carry_flag;
      end
      OP_AND:   r.result = a & b;
      OP_OR:    r.result = a | b;
      OP_XOR:   r.result = a ^ b;
      OP_MOVHI: r.result = a << 16;
      OP_SLL:   r.result = a << sh;
      OP_SRL:   r.result = a >> sh;
      OP_SRA:   r.result = $signed(a) >>> sh;
      OP_ROR:   r.result = (a >> sh) | (a << (6'd32 - sh));
      OP_EQ:    begin is_cmp = 1; cmpf = a == b; end
      OP_NE:    begin is_cmp = 1; cmpf = a != b; end
      OP_GTS:   begin is_cmp = 1; cmpf = $signed(a) > $signed(b); end
      OP_GES:   begin is_cmp = 1; cmpf = $signed(a) >= $signed(b); end
      OP_LTS:   begin is_cmp = 1; cmpf = $signed(a) < $signed(b); end
      OP_LES:   begin is_cmp = 1; cmpf = $signed(a) <= $signed(b); end
      OP_GTU:   begin is_cmp = 1; cmpf = a > b; end
      OP_GEU:   begin is_cmp = 1; cmpf = a >= b; end
      OP_LTU:   begin is_cmp = 1; cmpf = a < b; end
      OP_LEU:   begin is_cmp = 1; cmpf = a <= b; end
      OP_EXTBS: r.result = {{24{a[7]}}, a[7:0]};
      OP_EXTBZ: r.result = {24'd0, a[7:0]};
      OP_EXTHS: r.result = {{16{a[15]}}, a[15:0]};
      OP_EXTHZ: r.result = {16'd0, a[15:0]};
      OP_CMOV:  r.result = cmp_flag ? a : b;
      OP_FF1:   r.result = find_low_one(a);
      OP_FL1:   r.result = find_high_one(a);
      OP_MAC, OP_MSB: begin
        q = a * b;
        t = {{32{q[31]}}, q};
        mac_acc = (op.cmd == OP_MAC) ? mac_acc + t : mac_acc - t;
        r.wr = 1'b0;
      end
      OP_MACRC: begin
        r.result = mac_acc[31:0];
        mac_acc = '0;
      end
      default: r.wr = 1'b0;
    endcase
    if (is_cmp) begin
      cmp_flag = cmpf;
      r.wr = 1'b0;
    end
    if (!r.wr) r.result = '0;
    r.flag = cmp_flag;
    r.carry = carry_flag;
    r.ovf = ovf_flag;
    return r;
  endfunction

  // Drive operations from the pending queue; predict on each transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.cmd <= '0;
      in_ch.operand_a <= '0;
      in_ch.operand_b <= '0;
      send_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_res.push_back(alu_predict('{in_ch.cmd, in_ch.operand_a, in_ch.operand_b}));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (idle_enable && $urandom_range(0, 9) == 0) begin
          send_gap <= $urandom_range(0, 12);
          in_ch.valid <= 1'b0;
        end else if (!sender_hold && pending_ops.size() > 0) begin
          op_item_t op;
          op = pending_ops.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.cmd <= op.cmd;
          in_ch.operand_a <= op.a;
          in_ch.operand_b <= op.b;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Accept results with random stalls and compare them with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen <= results_seen + 1;
        if (expected_res.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result %h", out_ch.result);
        end else begin
          alu_res_t e;
          e = expected_res.pop_front();
          if (out_ch.result !== e.result || out_ch.writes_result !== e.wr ||
              out_ch.flag_out !== e.flag || out_ch.carry_out !== e.carry ||
              out_ch.overflow_out !== e.ovf || out_ch.range_exception !== e.exc) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: exp res=%h wr=%b f=%b c=%b v=%b x=%b got %h %b %b %b %b %b",
                       e.result, e.wr, e.flag, e.carry, e.ovf, e.exc, out_ch.result,
                       out_ch.writes_result, out_ch.flag_out, out_ch.carry_out,
                       out_ch.overflow_out, out_ch.range_exception);
          end
        end
      end
      if (long_stall) begin
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(0, 12);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic queue_op(logic [5:0] cmd, logic [31:0] a, logic [31:0] b);
    pending_ops.push_back('{cmd, a, b});
  endtask

  // Wait until all issued operations have returned, then let the unit idle.
  task automatic drain_unit();
    wait (pending_ops.size() == 0 && !in_ch.valid);
    wait (expected_res.size() == 0);
    repeat (50) @(posedge clk_i);
  endtask

  // Write the trap enable while the unit is idle.
  task automatic write_trap_enable(logic v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    trap_en = v;
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(0, 40);
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_random(int count, bit few_divides);
    logic [5:0] cmd;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 19) == 0) cmd = $urandom_range(35, 63);
      else cmd = $urandom_range(OP_ADD, OP_MACRC);
      if (few_divides && (cmd == OP_DIV || cmd == OP_DIVU) && $urandom_range(0, 1))
        cmd = OP_ADD;
      queue_op(cmd, pick_operand(), pick_operand());
    end
  endtask

  initial begin
    int phase_ops;
    trap_en = 0; cmp_flag = 0; carry_flag = 0; ovf_flag = 0; mac_acc = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed cases: extremes, division faults, wrap, rotates, mac chain.
    queue_op(OP_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
    queue_op(OP_ADDC, 32'hFFFF_FFFF, 32'h0000_0001);
    queue_op(OP_SUB, 32'h8000_0000, 32'h0000_0001);
    queue_op(OP_MUL, 32'h8000_0000, 32'hFFFF_FFFF);
    queue_op(OP_MULU, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_op(OP_DIV, 32'h1234_5678, 32'h0000_0000);
    queue_op(OP_DIVU, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_op(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
    queue_op(OP_DIV, 32'hFFFF_FFF9, 32'h0000_0002);
    queue_op(OP_ROR, 32'h8765_4321, 32'h0000_0020);
    queue_op(OP_SRA, 32'h8000_0000, 32'hFFFF_FFFF);
    queue_op(OP_FF1, 32'h0000_0000, 32'h0);
    queue_op(OP_FL1, 32'h8000_0000, 32'h0);
    queue_op(OP_GTS, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_op(OP_CMOV, 32'hAAAA_AAAA, 32'h5555_5555);
    queue_op(OP_LTU, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_op(OP_CMOV, 32'hAAAA_AAAA, 32'h5555_5555);
    queue_op(OP_MAC, 32'hFFFF_FFFF, 32'h0000_0003);
    queue_op(OP_MSB, 32'h8000_0000, 32'h0000_0002);
    queue_op(OP_MACRC, 32'h0, 32'h0);
    queue_op(OP_EXTBS, 32'h0000_0080, 32'h0);
    queue_op(OP_EXTHS, 32'h0000_8000, 32'h0);
    queue_op(6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain_unit();

    // Random phases over both trap settings.
    write_trap_enable(1'b1);
    queue_op(OP_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_op(OP_DIVU, 32'h5, 32'h0);
    queue_random(400, 1'b1);
    drain_unit();

    // Hold the receiver off so the front queue fills and stalls the input.
    long_stall = 1'b1;
    queue_random(60, 1'b1);
    repeat (300) @(posedge clk_i);
    long_stall = 1'b0;
    drain_unit();

    write_trap_enable(1'b0);
    queue_random(400, 1'b1);
    // Pause the sender until every result has come back.
    wait (pending_ops.size() == 0 && !in_ch.valid);
    sender_hold = 1'b1;
    queue_random(100, 1'b1);
    wait (expected_res.size() == 0);
    sender_hold = 1'b0;
    drain_unit();

    write_trap_enable(1'b1);
    idle_enable = 1'b0;
    phase_ops = 460;
    queue_random(phase_ops, 1'b1);
    drain_unit();

    $display("Covered all operations, division faults, mac chains and both trap settings;");
    $display("%0d results checked with random stalls on both channels.", results_seen);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("mismatches: %0d", mismatches);
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    out_ch.ready = 1'b0;
    #2000000;
    $display("timeout");
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### sim.f
rtl/rieu_pkg.sv
rtl/rieu_if.sv
rtl/rieu_front.sv
rtl/rieu_back.sv
rtl/risc_integer_execute_unit.sv
sim/risc_integer_execute_unit_tb.sv
